[hw/rtl/sssp_pkg.sv]
// ----------------------------------------------------------------------------
// sssp_pkg: shared constants and types
// field widths, register indexes and defaults for the shortest path unit
// ----------------------------------------------------------------------------
package sssp_pkg;

	// fixed field widths
	localparam int VTX_W    = 6;
	localparam int WIN_W    = 16;
	localparam int DIST_W   = 32;
	localparam int NV_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	// parameter defaults
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_EDGES    = 256;
	localparam int DEF_WEIGHT_BITS  = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES  = 2'd1;

	// register reset values
	localparam logic [VTX_W-1:0] SOURCE_RESET = '0;
	localparam logic [NV_W-1:0]  NUM_VERTICES_RESET = 7'd64;

	// outcome of one relaxation
	typedef struct packed {
		logic                     update;
		logic signed [DIST_W-1:0] cand;
	} relax_res_t;

endpackage

[hw/rtl/sssp_edge_if.sv]
// ----------------------------------------------------------------------------
// sssp_edge_if: edge input channel
// valid/ready channel carrying one edge per transfer
// ----------------------------------------------------------------------------
interface sssp_edge_if;
	logic                             valid;
	logic                             ready;
	logic [sssp_pkg::VTX_W-1:0]       from_vertex;
	logic [sssp_pkg::VTX_W-1:0]       to_vertex;
	logic signed [sssp_pkg::WIN_W-1:0] edge_weight;
	logic                             last_edge;

	modport source (output valid, from_vertex, to_vertex, edge_weight, last_edge,
		input ready);
	modport sink (input valid, from_vertex, to_vertex, edge_weight, last_edge,
		output ready);
endinterface

[hw/rtl/sssp_result_if.sv]
// ----------------------------------------------------------------------------
// sssp_result_if: result output channel
// valid/ready channel carrying one vertex distance per transfer
// ----------------------------------------------------------------------------
interface sssp_result_if;
	logic                              valid;
	logic                              ready;
	logic [sssp_pkg::VTX_W-1:0]        vertex_index;
	logic signed [sssp_pkg::DIST_W-1:0] distance;
	logic                              reachable;
	logic                              last_vertex;

	modport source (output valid, vertex_index, distance, reachable, last_vertex,
		input ready);
	modport sink (input valid, vertex_index, distance, reachable, last_vertex,
		output ready);
endinterface

[hw/rtl/single_source_shortest_path_unit.sv]
// ----------------------------------------------------------------------------
// single_source_shortest_path_unit: bellman-ford shortest path engine
// edges load into an edge ram, relaxation runs over a distance ram pair
// ----------------------------------------------------------------------------
// usage
//   edges:   one edge (tail, head, weight) per transfer, one per cycle while
//            loading; the transfer with last_edge set is stored too and starts
//            the computation. edges beyond MAX_EDGES are dropped.
//   results: num_vertices transfers, vertex 0 first, last_vertex on the final.
//   cfg:     source_vertex and num_vertices, written while the unit is idle.
// sequence
//   after the last edge: an init step, then (n-1) rounds over the E stored
//   edges, where a skipped edge takes a read step only and a relaxed edge a
//   read step and a relax step (edge ram read, then distance ram read and
//   write back), then per vertex result a distance read and an output step.
// reset and stall
//   reset clears the edge count, control state and registers to their
//   defaults. a stalled receiver holds the result register and the sequencer;
//   the next load starts as soon as the final result sits in the register.
// ----------------------------------------------------------------------------
module single_source_shortest_path_unit #(
	parameter int MAX_VERTICES = sssp_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = sssp_pkg::DEF_MAX_EDGES,
	parameter int WEIGHT_BITS  = sssp_pkg::DEF_WEIGHT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_en,
	input  logic [sssp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sssp_pkg::CFG_DATA_W-1:0]   cfg_data,
	sssp_edge_if.sink                         edges,
	sssp_result_if.source                     results
);

	localparam int VTX_W  = sssp_pkg::VTX_W;
	localparam int DIST_W = sssp_pkg::DIST_W;
	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
	localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECNT_W = $clog2(MAX_EDGES + 1);
	localparam int WEXT_W = (WEIGHT_BITS > sssp_pkg::WIN_W) ? WEIGHT_BITS : sssp_pkg::WIN_W;
	localparam int EDGE_W = 2 * VTX_W + WEIGHT_BITS;
	localparam int CMP_W  = VTX_W + 1;

	// sequencer states
	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_INIT  = 6'b000010,
		S_READ  = 6'b000100,
		S_RELAX = 6'b001000,
		S_ORD   = 6'b010000,
		S_OWR   = 6'b100000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [VTX_W-1:0]           source_q;
	logic [sssp_pkg::NV_W-1:0]  num_vertices_q;

	// run control
	logic [ECNT_W-1:0]          count_q;
	logic [EIDX_W-1:0]          e_q;
	logic [VCNT_W-1:0]          n_q;
	logic [VCNT_W-1:0]          rounds_q;
	logic [VIDX_W-1:0]          v_q;
	logic [MAX_VERTICES-1:0]    reached_q;

	// relax stage
	logic [VTX_W-1:0]           head_s1;
	logic [WEIGHT_BITS-1:0]     weight_s1;
	logic                       fin_s1;

	// result register
	logic                       ovalid_q;
	logic [VTX_W-1:0]           oidx_q;
	logic signed [DIST_W-1:0]   odist_q;
	logic                       oreach_q;
	logic                       olast_q;

	// ram ports
	logic                       edge_we;
	logic [EDGE_W-1:0]          edge_wdata;
	logic [EIDX_W-1:0]          edge_raddr;
	logic [EDGE_W-1:0]          edge_rdata;
	logic                       dist_we;
	logic [VIDX_W-1:0]          dist_waddr;
	logic signed [DIST_W-1:0]   dist_wdata;
	logic [VIDX_W-1:0]          dist_raddr_a;
	logic [VIDX_W-1:0]          dist_raddr_b;
	logic [DIST_W-1:0]          dist_rdata_a;
	logic [DIST_W-1:0]          dist_rdata_b;

	logic [WEXT_W-1:0]          weight_ext;
	logic [VTX_W-1:0]           e_tail;
	logic [VTX_W-1:0]           e_head;
	logic [WEIGHT_BITS-1:0]     e_weight;
	logic                       in_xfer;
	logic                       edge_last;
	logic                       run_final;
	logic                       edge_live;
	logic [EIDX_W-1:0]          e_next;
	logic [VCNT_W-1:0]          n_calc;
	logic                       src_ok;
	logic                       out_free;
	logic                       v_last;
	sssp_pkg::relax_res_t       relax;

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------
	assign edges.ready = (state_q == S_LOAD);
	assign in_xfer     = edges.valid && edges.ready;

	// upper weight bits beyond WEIGHT_BITS are dropped, sign comes from the top kept bit
	assign weight_ext = WEXT_W'($unsigned(edges.edge_weight));
	assign edge_wdata = {edges.from_vertex, edges.to_vertex, weight_ext[WEIGHT_BITS-1:0]};
	assign edge_we    = in_xfer && (count_q < ECNT_W'(MAX_EDGES));

	// stored edge fields
	assign e_tail   = edge_rdata[EDGE_W-1 -: VTX_W];
	assign e_head   = edge_rdata[EDGE_W-VTX_W-1 -: VTX_W];
	assign e_weight = edge_rdata[WEIGHT_BITS-1:0];

	// ------------------------------------------------------------------
	// sweep bookkeeping
	// ------------------------------------------------------------------
	assign edge_last = ((ECNT_W'(e_q) + ECNT_W'(1)) == count_q);
	assign e_next    = edge_last ? '0 : e_q + EIDX_W'(1);
	assign run_final = edge_last && (rounds_q == VCNT_W'(1));

	// only edges inside the vertex range with a reached tail are relaxed
	assign edge_live = (CMP_W'(e_tail) < CMP_W'(n_q)) && (CMP_W'(e_head) < CMP_W'(n_q))
		&& reached_q[e_tail[VIDX_W-1:0]];

	// effective vertex count: zero acts as one, clamp at MAX_VERTICES
	always_comb begin
		if (num_vertices_q == '0) begin
			n_calc = VCNT_W'(1);
		end else if (int'(num_vertices_q) > MAX_VERTICES) begin
			n_calc = VCNT_W'(MAX_VERTICES);
		end else begin
			n_calc = VCNT_W'(num_vertices_q);
		end
	end
	assign src_ok = (CMP_W'(source_q) < CMP_W'(n_calc));

	// edge ram read: in S_READ the next edge is fetched so it lands in the cycle after
	assign edge_raddr = (state_q == S_READ) ? e_next : e_q;

	// two distance copies: tail (or the result vertex outside S_READ) reads copy a, head reads copy b
	assign dist_raddr_a = (state_q == S_READ) ? e_tail[VIDX_W-1:0] : v_q;
	assign dist_raddr_b = e_head[VIDX_W-1:0];

	sssp_relax #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_relax (
		.dist_tail    ($signed(dist_rdata_a)),
		.dist_head    ($signed(dist_rdata_b)),
		.weight       (weight_s1),
		.head_reached (reached_q[head_s1[VIDX_W-1:0]]),
		.res          (relax)
	);

	// distance write: source seed at init, relaxed value on update
	always_comb begin
		dist_we    = 1'b0;
		dist_waddr = head_s1[VIDX_W-1:0];
		dist_wdata = relax.cand;
		if (state_q == S_INIT) begin
			dist_we    = src_ok;
			dist_waddr = source_q[VIDX_W-1:0];
			dist_wdata = '0;
		end else if (state_q == S_RELAX) begin
			dist_we    = relax.update;
		end
	end

	sssp_ram #(
		.WIDTH(EDGE_W),
		.DEPTH(MAX_EDGES)
	) u_edge_ram (
		.clk     (clk),
		.wr_en   (edge_we),
		.wr_addr (count_q[EIDX_W-1:0]),
		.wr_data (edge_wdata),
		.rd_addr (edge_raddr),
		.rd_data (edge_rdata)
	);

	sssp_ram #(
		.WIDTH(DIST_W),
		.DEPTH(MAX_VERTICES)
	) u_dist_ram_a (
		.clk     (clk),
		.wr_en   (dist_we),
		.wr_addr (dist_waddr),
		.wr_data (dist_wdata),
		.rd_addr (dist_raddr_a),
		.rd_data (dist_rdata_a)
	);

	sssp_ram #(
		.WIDTH(DIST_W),
		.DEPTH(MAX_VERTICES)
	) u_dist_ram_b (
		.clk     (clk),
		.wr_en   (dist_we),
		.wr_addr (dist_waddr),
		.wr_data (dist_wdata),
		.rd_addr (dist_raddr_b),
		.rd_data (dist_rdata_b)
	);

	// ------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------
	assign out_free = !ovalid_q || results.ready;
	assign v_last   = ((VCNT_W'(v_q) + VCNT_W'(1)) == n_q);

	assign results.valid        = ovalid_q;
	assign results.vertex_index = oidx_q;
	assign results.distance     = odist_q;
	assign results.reachable    = oreach_q;
	assign results.last_vertex  = olast_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q       <= sssp_pkg::SOURCE_RESET;
			num_vertices_q <= sssp_pkg::NUM_VERTICES_RESET;
		end else if (cfg_en) begin
			case (cfg_index)
				sssp_pkg::CFG_SOURCE_VERTEX: begin
					source_q <= cfg_data[VTX_W-1:0];
				end
				sssp_pkg::CFG_NUM_VERTICES: begin
					num_vertices_q <= cfg_data[sssp_pkg::NV_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			count_q   <= '0;
			e_q       <= '0;
			n_q       <= VCNT_W'(1);
			rounds_q  <= '0;
			v_q       <= '0;
			reached_q <= '0;
			fin_s1    <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			// result register fills in S_OWR, empties on a transfer
			if (state_q == S_OWR && out_free) begin
				ovalid_q <= 1'b1;
			end else if (results.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (edge_we) begin
						count_q <= count_q + ECNT_W'(1);
					end
					if (in_xfer && edges.last_edge) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					n_q       <= n_calc;
					rounds_q  <= n_calc - VCNT_W'(1);
					e_q       <= '0;
					v_q       <= '0;
					// only the source starts out reached
					reached_q <= src_ok ? (MAX_VERTICES'(1) << source_q[VIDX_W-1:0]) : '0;
					// single vertex or empty store: nothing to relax
					if (n_calc == VCNT_W'(1) || count_q == '0) begin
						state_q <= S_ORD;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					e_q <= e_next;
					if (edge_last) begin
						rounds_q <= rounds_q - VCNT_W'(1);
					end
					if (edge_live) begin
						fin_s1  <= run_final;
						state_q <= S_RELAX;
					end else if (run_final) begin
						state_q <= S_ORD;
					end
				end
				S_RELAX: begin
					if (relax.update) begin
						reached_q[head_s1[VIDX_W-1:0]] <= 1'b1;
					end
					state_q <= fin_s1 ? S_ORD : S_READ;
				end
				S_ORD: begin
					state_q <= S_OWR;
				end
				S_OWR: begin
					if (out_free) begin
						if (v_last) begin
							count_q <= '0;
							state_q <= S_LOAD;
						end else begin
							v_q     <= v_q + VIDX_W'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// relax stage payload, captured when the edge leaves the ram
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			head_s1   <= e_head;
			weight_s1 <= e_weight;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_OWR && out_free) begin
			oidx_q   <= VTX_W'(v_q);
			oreach_q <= reached_q[v_q];
			odist_q  <= reached_q[v_q] ? $signed(dist_rdata_a) : '0;
			olast_q  <= v_last;
		end
	end

endmodule

[hw/rtl/sssp_ram.sv]
// ----------------------------------------------------------------------------
// sssp_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sssp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[hw/rtl/sssp_relax.sv]
// ----------------------------------------------------------------------------
// sssp_relax: edge relaxation datapath
// saturating add of tail distance and weight, compare against head distance
// ----------------------------------------------------------------------------
module sssp_relax #(
	parameter int WEIGHT_BITS = sssp_pkg::DEF_WEIGHT_BITS
) (
	input  logic signed [sssp_pkg::DIST_W-1:0] dist_tail,
	input  logic signed [sssp_pkg::DIST_W-1:0] dist_head,
	input  logic [WEIGHT_BITS-1:0]             weight,
	input  logic                               head_reached,
	output sssp_pkg::relax_res_t               res
);

	localparam int SUM_W = sssp_pkg::DIST_W + 1;

	logic signed [SUM_W-1:0]           sum;
	logic signed [sssp_pkg::DIST_W-1:0] sat;

	always_comb begin
		sum = SUM_W'(dist_tail) + SUM_W'($signed(weight));
		// clamp to the signed 32-bit range
		if (sum[SUM_W-1] != sum[SUM_W-2]) begin
			sat = sum[SUM_W-1] ? {1'b1, {(sssp_pkg::DIST_W-1){1'b0}}}
				: {1'b0, {(sssp_pkg::DIST_W-1){1'b1}}};
		end else begin
			sat = sum[sssp_pkg::DIST_W-1:0];
		end
		res.cand   = sat;
		res.update = !head_reached || (sat < dist_head);
	end

endmodule
